// ===== sv/jsu_pkg.sv =====
// Package with the types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int JOB_BYTES   = 3;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
   localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_BYTE    = 3'd0,
      ST_CLOSED  = 3'd1,
      ST_NOQUOTE = 3'd2,
      ST_END     = 3'd3,
      ST_BADESC  = 3'd4,
      ST_BADHEX  = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]                 count;
      status_type                 status;
      logic [JOB_BYTES-1:0][7:0]  data;
   } job_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type r;
      r.valid  = 1'b1;
      r.nibble = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.nibble = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         r.nibble = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         r.nibble = 4'(c - 8'h37);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== sv/jsu_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the unescaper.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] text_byte;

   modport source (output valid, output command, output text_byte, input ready);
   modport sink (input valid, input command, input text_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output status, output out_byte, output last, input ready);
   modport sink (input valid, input status, input out_byte, input last, output ready);
endinterface

// ===== sv/json_string_unescape_unit.sv =====
// Top level of the JSON string unescaper: parser front end, job queue and result back end.
//
//   Channel   Direction  Beat contents
//   req_chan  in         command, text_byte
//   rsp_chan  out        status, out_byte, last
//
// The front end takes one request beat per cycle while the job queue has room.
// The back end sends one response beat per cycle while the response side is ready;
// a request yields one beat or none, or one per byte of a \u escape's UTF-8 encoding.
// A response goes through a job queue entry and then the back end's output register.
// Reset is synchronous and returns the parser to waiting for an opening quote.
// A stalled response fills the four-entry job queue before the request side stalls.
module json_string_unescape_unit (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);
   import jsu_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_BYTE) |-> rsp_chan.last)
      else $error("Non-byte status beat is not marked last.");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_chan.ready)
      else $error("Request accepted while the job queue is full.");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_status.head_valid |-> (head.count != 2'd0))
      else $error("Queued job carries no response beats.");

   a_pop_with_beat: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_chan.valid && rsp_chan.last))
      else $error("Job retired without a final response beat.");

endmodule

// ===== sv/jsu_front.sv =====
// Front end: accepts request beats, runs the string parser and builds result jobs.
module jsu_front (
   input  logic                       clock,
   input  logic                       reset,
   jsu_req_if.sink                    req_chan,
   input  jsu_pkg::queue_status_type  q_status,
   output logic                       push,
   output jsu_pkg::job_type           push_job
);
   import jsu_pkg::*;

   mode_type      mode_ff, mode_in;
   logic [1:0]    hex_cnt_ff, hex_cnt_in;
   logic [11:0]   code_ff, code_in;
   logic          accept;
   hex_digit_type hd;
   logic [15:0]   cp;
   job_type       job;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign hd             = hex_value(req_chan.text_byte);
   assign cp             = {code_ff, hd.nibble};

   always_comb begin
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      code_in    = code_ff;
      if (req_chan.command) begin
         mode_in    = MODE_IDLE;
         hex_cnt_in = 2'd0;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               if (req_chan.text_byte == CH_QUOTE) begin
                  mode_in = MODE_STR;
               end
            end
            MODE_STR: begin
               if (req_chan.text_byte == CH_QUOTE) begin
                  mode_in    = MODE_IDLE;
                  hex_cnt_in = 2'd0;
               end else if (req_chan.text_byte == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_STR;
               if (req_chan.text_byte == CH_LOW_U) begin
                  mode_in    = MODE_HEX;
                  hex_cnt_in = 2'd0;
                  code_in    = 12'd0;
               end else if (!(req_chan.text_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH,
                     CH_LOW_N, CH_LOW_T, CH_LOW_R, CH_LOW_B, CH_LOW_F})) begin
                  mode_in    = MODE_IDLE;
                  hex_cnt_in = 2'd0;
               end
            end
            MODE_HEX: begin
               if (!hd.valid) begin
                  mode_in    = MODE_IDLE;
                  hex_cnt_in = 2'd0;
               end else if (hex_cnt_ff == 2'd3) begin
                  mode_in    = MODE_STR;
                  hex_cnt_in = 2'd0;
               end else begin
                  code_in    = {code_ff[7:0], hd.nibble};
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      job.count  = 2'd0;
      job.status = ST_BYTE;
      job.data   = '0;
      if (req_chan.command) begin
         job.count  = 2'd1;
         job.status = ST_END;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               if (req_chan.text_byte != CH_QUOTE) begin
                  job.count  = 2'd1;
                  job.status = ST_NOQUOTE;
               end
            end
            MODE_STR: begin
               if (req_chan.text_byte == CH_QUOTE) begin
                  job.count  = 2'd1;
                  job.status = ST_CLOSED;
               end else if (req_chan.text_byte != CH_BSLASH) begin
                  job.count   = 2'd1;
                  job.data[0] = req_chan.text_byte;
               end
            end
            MODE_ESC: begin
               case (req_chan.text_byte)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                     job.count   = 2'd1;
                     job.data[0] = req_chan.text_byte;
                  end
                  CH_LOW_N: begin
                     job.count   = 2'd1;
                     job.data[0] = CH_LF;
                  end
                  CH_LOW_T: begin
                     job.count   = 2'd1;
                     job.data[0] = CH_TAB;
                  end
                  CH_LOW_R: begin
                     job.count   = 2'd1;
                     job.data[0] = CH_CR;
                  end
                  CH_LOW_B, CH_LOW_F, CH_LOW_U: begin
                     job.count = 2'd0;
                  end
                  default: begin
                     job.count  = 2'd1;
                     job.status = ST_BADESC;
                  end
               endcase
            end
            MODE_HEX: begin
               if (!hd.valid) begin
                  job.count  = 2'd1;
                  job.status = ST_BADHEX;
               end else if (hex_cnt_ff == 2'd3) begin
                  if (cp < CP_TWO_BYTE) begin
                     job.count   = 2'd1;
                     job.data[0] = cp[7:0];
                  end else if (cp < CP_THREE_BYTE) begin
                     job.count   = 2'd2;
                     job.data[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                     job.data[1] = UTF8_CONT | {2'd0, cp[5:0]};
                  end else begin
                     job.count   = 2'd3;
                     job.data[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                     job.data[1] = UTF8_CONT | {2'd0, cp[11:6]};
                     job.data[2] = UTF8_CONT | {2'd0, cp[5:0]};
                  end
               end
            end
            default: begin
               job.count = 2'd0;
            end
         endcase
      end
   end

   assign push     = accept && (job.count != 2'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         hex_cnt_ff <= 2'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= code_in;
      end
   end

endmodule

// ===== sv/jsu_queue.sv =====
// Short job queue that decouples the parser front end from the result back end.
module jsu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  jsu_pkg::job_type           push_job,
   input  logic                       pop,
   output jsu_pkg::queue_status_type  q_status,
   output jsu_pkg::job_type           head
);
   import jsu_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_status.full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.head_valid = (cnt_ff != '0);
   assign head                = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.head_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/jsu_back.sv =====
// Back end: walks head job bytes, driving one registered response beat per cycle while ready.
module jsu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  jsu_pkg::queue_status_type  q_status,
   input  jsu_pkg::job_type           head,
   output logic                       pop,
   jsu_rsp_if.source                  rsp_chan
);
   import jsu_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   status_type status_ff, status_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;

   assign load    = !valid_ff || rsp_chan.ready;
   assign is_last = (idx_ff == (head.count - 2'd1));

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in  = q_status.head_valid;
         status_in = head.status;
         byte_in   = head.data[idx_ff];
         last_in   = is_last;
         if (q_status.head_valid) begin
            if (is_last) begin
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.last     = last_ff;

endmodule
